// ===== hw/rtl/size_class_block_pool_top_assert.svh =====
// Assertion macros for the size-class block pool
`ifndef SIZE_CLASS_BLOCK_POOL_TOP_ASSERT_SVH
`define SIZE_CLASS_BLOCK_POOL_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle, masked in reset
`define SCB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scb assertion failed");

// antecedent implies consequent in the next cycle, masked in reset
`define SCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scb assertion failed");

// condition holds in the cycle after reset is applied
`define SCB_ASSERT_RST(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("scb reset assertion failed");

`endif

// ===== hw/rtl/scb_pkg.sv =====
// ----------------------------------------------------------------------------
// scb_pkg
// Shared codes and types for the size-class block pool.
// ----------------------------------------------------------------------------
`default_nettype none

package scb_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned REQ_W    = 48;
  localparam int unsigned BIDX_W   = 8;
  localparam int unsigned ACTIVE_W = 32;
  localparam int unsigned HELD_W   = 11;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_GRANT   = 3'd1,
    ACT_RECLAIM = 3'd2,
    ACT_FREE    = 3'd3,
    ACT_DRAIN   = 3'd4
  } scb_action_t;

  typedef enum logic [3:0] {
    ST_HIT       = 4'd0,
    ST_MISS      = 4'd1,
    ST_GRANTED   = 4'd2,
    ST_RECLAIMED = 4'd3,
    ST_OOM       = 4'd4,
    ST_HELD      = 4'd5,
    ST_BIN_FULL  = 4'd6,
    ST_DRAINED   = 4'd7,
    ST_NONE_HELD = 4'd8
  } scb_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_RDFILL,
    S_FILL,
    S_RDSTK,
    S_OUT
  } scb_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scb_in_if.sv =====
// ----------------------------------------------------------------------------
// scb_in_if
// Request channel: one word per pool operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface scb_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    action;
  logic [scb_pkg::REQ_W-1:0]     request_size;
  logic [scb_pkg::ADDR_W-1:0]    in_address;

  modport source (output valid, output action, output request_size, output in_address,
                  input ready);
  modport sink   (input valid, input action, input request_size, input in_address,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scb_out_if.sv =====
// ----------------------------------------------------------------------------
// scb_out_if
// Result channel: one word per accepted operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface scb_out_if;
  logic                          valid;
  logic                          ready;
  logic [3:0]                    status;
  logic [scb_pkg::ADDR_W-1:0]    out_address;
  logic [scb_pkg::ADDR_W-1:0]    backing_size;
  logic [scb_pkg::BIDX_W-1:0]    bin_index;
  logic [scb_pkg::ACTIVE_W-1:0]  active_count;
  logic [scb_pkg::HELD_W-1:0]    held_count;
  logic                          flush_due;

  modport source (output valid, output status, output out_address, output backing_size,
                  output bin_index, output active_count, output held_count,
                  output flush_due, input ready);
  modport sink   (input valid, input status, input out_address, input backing_size,
                  input bin_index, input active_count, input held_count,
                  input flush_due, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scb_ram.sv =====
// ----------------------------------------------------------------------------
// scb_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scb_prio.sv =====
// ----------------------------------------------------------------------------
// scb_prio
// Registered priority search: first picks a group of eight, then a bit in it.
// Finds the highest or lowest set bit of a vector.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_prio #(
  parameter int unsigned W = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 dir_hi,
  input  wire logic [W-1:0]         vec,
  output logic                      done,
  output logic                      found,
  output logic [$clog2(W)-1:0]      idx
);

  localparam int unsigned G  = 8;
  localparam int unsigned NG = (W + G - 1) / G;
  localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned SW = $clog2(G);
  localparam int unsigned IW = $clog2(W);

  logic [NG*G-1:0] vec_pad;
  logic [NG-1:0]   any;
  logic [GW-1:0]   grp;
  logic [GW-1:0]   grp_r;
  logic [G-1:0]    bits_r;
  logic            found_r;
  logic            dir_r;
  logic            done_r;
  logic [SW-1:0]   sub;

  assign vec_pad = (NG*G)'(vec);

  always_comb begin
    grp = '0;
    for (int g = 0; g < NG; g++) begin
      any[g] = |vec_pad[g*G +: G];
    end
    if (dir_hi) begin
      for (int g = 0; g < NG; g++) begin
        if (any[g]) grp = GW'(g);
      end
    end else begin
      for (int g = NG - 1; g >= 0; g--) begin
        if (any[g]) grp = GW'(g);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
    if (start) begin
      grp_r   <= grp;
      bits_r  <= vec_pad[grp*G +: G];
      found_r <= |any;
      dir_r   <= dir_hi;
    end
  end

  always_comb begin
    sub = '0;
    if (dir_r) begin
      for (int b = 0; b < G; b++) begin
        if (bits_r[b]) sub = SW'(b);
      end
    end else begin
      for (int b = G - 1; b >= 0; b--) begin
        if (bits_r[b]) sub = SW'(b);
      end
    end
  end

  assign done  = done_r;
  assign found = found_r;
  assign idx   = found_r ? IW'((IW'(grp_r) << SW) | IW'(sub)) : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/size_class_block_pool_top.sv =====
// ----------------------------------------------------------------------------
// size_class_block_pool_top
// Caches released blocks in size-class bins held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : request words (action, request_size, in_address), valid/ready.
//   out_if : one result word per accepted request; actions 5 to 7 are
//            dropped and give no result.
//   One request is in flight at a time; in_if.ready is high only when idle.
//   A grant goes straight to the result word. Other requests pass the
//   priority search, then the fill-count RAM read, and for a hit,
//   reclaim or drain the bin-stack RAM read; a reclaim or drain with
//   nothing held skips both RAM reads.
//   The next request can be accepted from the cycle after the result
//   word is loaded, never before that.
//   A new request may be accepted while the previous result word waits in
//   the output register; a stalled out_if holds that word and the next
//   result waits in the pipeline until it has gone.
//   Reset: synchronous, active low. Afterwards a clearing pass zeroes all
//   NUM_BINS entries of the fill-count RAM; no request is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_pool_top #(
  parameter int unsigned SIZE_BITS      = 48,
  parameter int unsigned BIN_DEPTH      = 8,
  parameter int unsigned MANTISSA_WIDTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  scb_in_if.sink     in_if,
  scb_out_if.source  out_if
);

  localparam int unsigned NUM_BINS = SIZE_BITS << MANTISSA_WIDTH;
  localparam int unsigned BW       = $clog2(NUM_BINS);
  localparam int unsigned EW       = $clog2(SIZE_BITS);
  localparam int unsigned FW       = $clog2(BIN_DEPTH + 1);
  localparam int unsigned NSLOT    = NUM_BINS * BIN_DEPTH;
  localparam int unsigned SA       = $clog2(NSLOT);
  localparam int unsigned HW       = $clog2(NSLOT + 1);
  localparam logic [SIZE_BITS-1:0] MANT_MASK = SIZE_BITS'((1 << MANTISSA_WIDTH) - 1);
  localparam logic [scb_pkg::ACTIVE_W-1:0] ACTIVE_MAX = '1;

  scb_pkg::scb_state_t state_r, state_nxt;

  logic [2:0]                   act_r;
  logic [SIZE_BITS-1:0]         size_r;
  logic [scb_pkg::ADDR_W-1:0]   addr_r;
  logic [BW-1:0]                bin_r, bin_nxt;
  logic                         found_r;
  logic [FW-1:0]                fill_r;
  logic [BW-1:0]                clr_cnt_r;
  logic [NUM_BINS-1:0]          nonempty_r;
  logic [scb_pkg::ACTIVE_W-1:0] active_r, active_nxt;
  logic [HW-1:0]                held_r, held_nxt;

  logic                         in_acc;
  logic                         log_start, find_start;
  logic                         log_done, log_found, find_done, find_found;
  logic [EW-1:0]                log_idx;
  logic [BW-1:0]                find_idx;
  logic [SIZE_BITS-1:0]         in_size;
  logic [SIZE_BITS-1:0]         top;
  logic [SIZE_BITS-1:0]         lead, bsize;
  logic [BW-1:0]                e_of_bin;

  logic                         fill_we, fill_re;
  logic [BW-1:0]                fill_waddr;
  logic [FW-1:0]                fill_wdata, fill_rdata;
  logic                         stk_we, stk_re;
  logic [SA-1:0]                stk_addr;
  logic [scb_pkg::ADDR_W-1:0]   stk_rdata;
  logic                         pop;
  logic                         push;
  logic                         out_load;

  logic                         out_valid_r;
  logic [3:0]                   out_status_r;
  logic [scb_pkg::ADDR_W-1:0]   out_addr_r, out_bsize_r;
  logic [scb_pkg::BIDX_W-1:0]   out_bin_r;
  logic                         out_flush_r;
  scb_pkg::scb_status_t         res_status;
  logic [scb_pkg::ADDR_W-1:0]   res_addr, res_bsize;
  logic [scb_pkg::BIDX_W-1:0]   res_bin;
  logic                         res_flush;

  assign in_if.ready = (state_r == scb_pkg::S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign in_size     = SIZE_BITS'(in_if.request_size);
  assign log_start   = in_acc && (in_if.action == scb_pkg::ACT_ALLOC ||
                                  in_if.action == scb_pkg::ACT_FREE);
  assign find_start  = in_acc && (in_if.action == scb_pkg::ACT_RECLAIM ||
                                  in_if.action == scb_pkg::ACT_DRAIN);

  scb_prio #(.W(SIZE_BITS)) u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .dir_hi (1'b1),
    .vec    (in_size),
    .done   (log_done),
    .found  (log_found),
    .idx    (log_idx)
  );

  scb_prio #(.W(NUM_BINS)) u_find (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (find_start),
    .dir_hi (in_if.action == scb_pkg::ACT_RECLAIM),
    .vec    (nonempty_r),
    .done   (find_done),
    .found  (find_found),
    .idx    (find_idx)
  );

  scb_ram #(.DEPTH(NUM_BINS), .WIDTH(FW)) u_fill_ram (
    .clk     (clk),
    .we      (fill_we),
    .waddr   (fill_waddr),
    .wdata   (fill_wdata),
    .re      (fill_re),
    .raddr   (bin_r),
    .rdata_r (fill_rdata)
  );

  scb_ram #(.DEPTH(NSLOT), .WIDTH(scb_pkg::ADDR_W)) u_stack_ram (
    .clk     (clk),
    .we      (stk_we),
    .waddr   (stk_addr),
    .wdata   (addr_r),
    .re      (stk_re),
    .raddr   (stk_addr),
    .rdata_r (stk_rdata)
  );

  // size to bin; a zero size has no leading one and maps like size one
  always_comb begin
    if (log_found && 32'(log_idx) >= MANTISSA_WIDTH) begin
      top = size_r >> (32'(log_idx) - MANTISSA_WIDTH);
    end else begin
      top = size_r << (MANTISSA_WIDTH - 32'(log_idx));
    end
    bin_nxt = BW'((BW'(log_idx) << MANTISSA_WIDTH) | BW'(top & MANT_MASK));
  end

  // bin to rounded-up size
  always_comb begin
    e_of_bin = bin_r >> MANTISSA_WIDTH;
    lead     = SIZE_BITS'(1 << MANTISSA_WIDTH) | (SIZE_BITS'(bin_r) & MANT_MASK);
    if (32'(e_of_bin) >= MANTISSA_WIDTH) begin
      bsize = (lead << (32'(e_of_bin) - MANTISSA_WIDTH)) |
              ((SIZE_BITS'(1) << (32'(e_of_bin) - MANTISSA_WIDTH)) - SIZE_BITS'(1));
    end else begin
      bsize = lead >> (MANTISSA_WIDTH - 32'(e_of_bin));
    end
  end

  assign pop  = (act_r == scb_pkg::ACT_ALLOC && fill_rdata != '0) ||
                act_r == scb_pkg::ACT_RECLAIM || act_r == scb_pkg::ACT_DRAIN;
  assign push = (act_r == scb_pkg::ACT_FREE) && (fill_rdata < FW'(BIN_DEPTH));

  assign out_load = (state_r == scb_pkg::S_OUT) && (!out_valid_r || out_if.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scb_pkg::S_CLEAR: begin
        if (clr_cnt_r == BW'(NUM_BINS - 1)) state_nxt = scb_pkg::S_IDLE;
      end
      scb_pkg::S_IDLE: begin
        if (log_start || find_start) begin
          state_nxt = scb_pkg::S_FIND;
        end else if (in_acc && in_if.action == scb_pkg::ACT_GRANT) begin
          state_nxt = scb_pkg::S_OUT;
        end
      end
      scb_pkg::S_FIND: begin
        if (log_done || (find_done && find_found)) begin
          state_nxt = scb_pkg::S_RDFILL;
        end else if (find_done) begin
          state_nxt = scb_pkg::S_OUT;
        end
      end
      scb_pkg::S_RDFILL: state_nxt = scb_pkg::S_FILL;
      scb_pkg::S_FILL:   state_nxt = pop ? scb_pkg::S_RDSTK : scb_pkg::S_OUT;
      scb_pkg::S_RDSTK:  state_nxt = scb_pkg::S_OUT;
      scb_pkg::S_OUT: begin
        if (out_load) state_nxt = scb_pkg::S_IDLE;
      end
      default: state_nxt = scb_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = bin_r;
    fill_wdata = '0;
    fill_re    = 1'b0;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_addr   = SA'(SA'(bin_r) * SA'(BIN_DEPTH)) + SA'(fill_rdata);
    unique case (state_r)
      scb_pkg::S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_cnt_r;
      end
      scb_pkg::S_RDFILL: fill_re = 1'b1;
      scb_pkg::S_FILL: begin
        if (pop) begin
          fill_we    = 1'b1;
          fill_wdata = fill_rdata - FW'(1);
          stk_re     = 1'b1;
          stk_addr   = SA'(SA'(bin_r) * SA'(BIN_DEPTH)) + SA'(fill_rdata - FW'(1));
        end else if (push) begin
          fill_we    = 1'b1;
          fill_wdata = fill_rdata + FW'(1);
          stk_we     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result fields and counter updates
  always_comb begin
    res_status = scb_pkg::ST_GRANTED;
    res_addr   = '0;
    res_bsize  = '0;
    res_bin    = '0;
    res_flush  = 1'b0;
    active_nxt = active_r;
    held_nxt   = held_r;
    case (act_r)
      scb_pkg::ACT_ALLOC: begin
        res_bin = scb_pkg::BIDX_W'(bin_r);
        if (fill_r != '0) begin
          res_status = scb_pkg::ST_HIT;
          res_addr   = stk_rdata;
          held_nxt   = held_r - HW'(1);
          if (active_r != ACTIVE_MAX) active_nxt = active_r + 1'b1;
        end else begin
          res_status = scb_pkg::ST_MISS;
          res_bsize  = scb_pkg::ADDR_W'(bsize);
        end
      end
      scb_pkg::ACT_GRANT: begin
        res_status = scb_pkg::ST_GRANTED;
        if (active_r != ACTIVE_MAX) active_nxt = active_r + 1'b1;
      end
      scb_pkg::ACT_RECLAIM, scb_pkg::ACT_DRAIN: begin
        if (found_r) begin
          res_status = (act_r == scb_pkg::ACT_RECLAIM) ? scb_pkg::ST_RECLAIMED
                                                        : scb_pkg::ST_DRAINED;
          res_addr   = stk_rdata;
          res_bin    = scb_pkg::BIDX_W'(bin_r);
          held_nxt   = held_r - HW'(1);
        end else begin
          res_status = (act_r == scb_pkg::ACT_RECLAIM) ? scb_pkg::ST_OOM
                                                        : scb_pkg::ST_NONE_HELD;
        end
      end
      scb_pkg::ACT_FREE: begin
        res_bin = scb_pkg::BIDX_W'(bin_r);
        if (active_r != '0) active_nxt = active_r - 1'b1;
        if (fill_r < FW'(BIN_DEPTH)) begin
          res_status = scb_pkg::ST_HELD;
          held_nxt   = held_r + HW'(1);
        end else begin
          res_status = scb_pkg::ST_BIN_FULL;
          res_addr   = addr_r;
        end
        res_flush = (active_nxt == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scb_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      nonempty_r  <= '0;
      active_r    <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == scb_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + BW'(1);
      if (state_r == scb_pkg::S_FILL) begin
        if (pop && fill_rdata == FW'(1)) nonempty_r[bin_r] <= 1'b0;
        if (push) nonempty_r[bin_r] <= 1'b1;
      end
      if (out_load) begin
        active_r    <= active_nxt;
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_if.action;
      size_r <= in_size;
      addr_r <= in_if.in_address;
    end
    if (state_r == scb_pkg::S_FIND) begin
      if (log_done) bin_r <= bin_nxt;
      if (find_done) begin
        bin_r   <= find_idx;
        found_r <= find_found;
      end
    end
    if (state_r == scb_pkg::S_FILL) fill_r <= fill_rdata;
    if (out_load) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_bsize_r  <= res_bsize;
      out_bin_r    <= res_bin;
      out_flush_r  <= res_flush;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.out_address  = out_addr_r;
  assign out_if.backing_size = out_bsize_r;
  assign out_if.bin_index    = out_bin_r;
  assign out_if.active_count = active_r;
  assign out_if.held_count   = scb_pkg::HELD_W'(held_r);
  assign out_if.flush_due    = out_flush_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scb_checker.sv =====
// ----------------------------------------------------------------------------
// scb_checker
// Port-level checks on the size-class block pool, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "size_class_block_pool_top_assert.svh"

module scb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  status,
  input wire logic [47:0] backing_size,
  input wire logic        flush_due
);

  `SCB_ASSERT_RST(a_no_result_after_reset, clk, rst_n, !out_valid && !in_ready)
  `SCB_ASSERT_NEXT(a_result_held_on_stall, clk, rst_n, out_valid && !out_ready, out_valid)
  `SCB_ASSERT_SAME(a_flush_only_on_free, clk, rst_n, out_valid && flush_due,
    status == scb_pkg::ST_HELD || status == scb_pkg::ST_BIN_FULL)
  `SCB_ASSERT_SAME(a_backing_only_on_miss, clk, rst_n, out_valid && backing_size != '0,
    status == scb_pkg::ST_MISS)

endmodule

bind size_class_block_pool_top scb_checker u_scb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .status       (out_if.status),
  .backing_size (out_if.backing_size),
  .flush_due    (out_if.flush_due)
);

`default_nettype wire
